// ===== rtl/disk_channel_program_builder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the disk channel program builder
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DISK_CHANNEL_PROGRAM_BUILDER_UNIT_ASSERT_SVH
`define DISK_CHANNEL_PROGRAM_BUILDER_UNIT_ASSERT_SVH

// checked outside reset only
`define DCPB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcpb check failed");

// checked on every edge, reset included
`define DCPB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dcpb check failed");

`endif

// ===== rtl/dcpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcpb_pkg
// Command codes, flag bytes, error codes, field widths and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcpb_pkg;

  localparam int BLK_W  = 16;
  localparam int BUF_W  = 24;
  localparam int OPND_W = 58;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 13;
  localparam int CYL_W  = 10;
  localparam int HEAD_W = 5;
  localparam int SEC_W  = 8;
  localparam int REM_W  = 13;   // remainder within one cylinder, below 31*255
  localparam int CH_W   = CYL_W + HEAD_W;
  localparam int NBLK_W = 5;

  localparam logic [7:0] CMD_SEEK   = 8'h07;
  localparam logic [7:0] CMD_SEARCH = 8'h31;
  localparam logic [7:0] CMD_BRANCH = 8'h08;
  localparam logic [7:0] CMD_READ   = 8'h06;
  localparam logic [7:0] CMD_WRITE  = 8'h05;
  // error words carry neither a command nor flags
  localparam logic [7:0] CMD_NONE   = 8'h00;

  localparam logic [7:0] FLG_SEEK   = 8'h64;
  localparam logic [7:0] FLG_SEARCH = 8'h54;
  localparam logic [7:0] FLG_BRANCH = 8'h0C;
  localparam logic [7:0] FLG_XCHG   = 8'h04;
  localparam logic [7:0] FLG_FINAL  = 8'h00;
  localparam logic [7:0] FLG_NONE   = 8'h00;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;

  localparam logic [7:0] DEV_ADDR_RESET = 8'd56;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic             first_block;
    logic             last_block;
    logic             read_request;
    logic [BUF_W-1:0] buffer_address;
  } dcpb_req_t;

  typedef struct packed {
    logic              out_of_range;
    logic [CYL_W-1:0]  cyl;
    logic [HEAD_W-1:0] head;
    logic [SEC_W-1:0]  sec;
  } dcpb_geom_t;

endpackage

`default_nettype wire

// ===== rtl/dcpb_ifs.sv =====
// ----------------------------------------------------------------------------
// dcpb channel interfaces
// Valid/ready channels for requests, command words and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcpb_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_number;
  logic        first_block;
  logic        last_block;
  logic        read_request;
  logic [23:0] buffer_address;

  modport source (output valid, block_number, first_block, last_block, read_request,
                  buffer_address, input ready);
  modport sink   (input valid, block_number, first_block, last_block, read_request,
                  buffer_address, output ready);
endinterface

interface dcpb_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [7:0]  command_flags;
  logic [12:0] word_count;
  logic [7:0]  unit_code;
  logic [57:0] operand;
  logic [5:0]  program_index;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, command_code, command_flags, word_count, unit_code,
                  operand, program_index, error_code, last_of_run, input ready);
  modport sink   (input valid, command_code, command_flags, word_count, unit_code,
                  operand, program_index, error_code, last_of_run, output ready);
endinterface

interface dcpb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/disk_channel_program_builder_unit.sv =====
// A request passes the four geometry stages and then the result register before its first command word.
// Throughput: one command word per cycle on the result channel while command.ready is high;
//   a block gives three or four words (one for an error result).
// The 4-stage geometry pipe advances only when the result register is free to load.
// Reset (rst, synchronous): empties the pipe, clears program position, block
//   count and previous cylinder/head, and loads device_address with 56.
// ----------------------------------------------------------------------------
// disk_channel_program_builder_unit
// Builds seek/search/branch/exchange channel command words per disk block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disk_channel_program_builder_unit import dcpb_pkg::*; #(
  parameter int CYLINDERS              = 808,
  parameter int HEADS                  = 19,
  parameter int SECTORS_PER_TRACK      = 3,
  parameter int MAX_BLOCKS_PER_PROGRAM = 16,
  parameter int WORDS_PER_BLOCK        = 512
) (
  input logic        clk,
  input logic        rst,
  dcpb_cfg_if.sink   cfg,
  dcpb_req_if.sink   request,
  dcpb_cmd_if.source command
);

  typedef enum logic [1:0] {WK_SEEK, WK_SEARCH, WK_BRANCH, WK_XCHG} word_kind_t;

  localparam logic [NBLK_W-1:0] MAX_V   = NBLK_W'(MAX_BLOCKS_PER_PROGRAM);
  localparam logic [CNT_W-1:0]  COUNT_V = CNT_W'(WORDS_PER_BLOCK);

  logic [7:0]        device_address;
  logic [CH_W-1:0]   previous_cyl_head;
  logic [IDX_W-1:0]  program_position;
  logic [NBLK_W-1:0] blocks_in_program;

  // result register
  logic              e_valid;
  logic [1:0]        e_err;
  logic              e_seek;
  logic [IDX_W-1:0]  e_pos;
  logic [1:0]        e_step;
  logic [CYL_W-1:0]  e_cyl;
  logic [HEAD_W-1:0] e_head;
  logic [SEC_W-1:0]  e_sec;
  logic              e_rd;
  logic              e_last;
  logic [BUF_W-1:0]  e_buf;

  logic       g_valid;
  dcpb_req_t  g_item;
  dcpb_geom_t g_geom;
  dcpb_req_t  req_item;

  logic              pipe_move, load;
  logic [IDX_W-1:0]  pos_base;
  logic [NBLK_W-1:0] nblk_base;
  logic [CH_W-1:0]   ch;
  logic [1:0]        err;
  logic              seek;

  word_kind_t        e_kind;
  logic              e_is_last;
  logic [IDX_W-1:0]  search_idx;
  logic [OPND_W-1:0] seek_word, search_word;

  assign req_item.block_number   = request.block_number;
  assign req_item.first_block    = request.first_block;
  assign req_item.last_block     = request.last_block;
  assign req_item.read_request   = request.read_request;
  assign req_item.buffer_address = request.buffer_address;

  assign pipe_move     = !e_valid || (command.ready && e_is_last);
  assign request.ready = pipe_move;
  assign cfg.ready     = 1'b1;

  dcpb_geom #(
    .CYLINDERS         (CYLINDERS),
    .HEADS             (HEADS),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .advance   (pipe_move),
    .in_valid  (request.valid),
    .in_item   (req_item),
    .out_valid (g_valid),
    .out_item  (g_item),
    .out_geom  (g_geom)
  );

  // decisions for the block entering the result register
  assign load      = pipe_move && g_valid;
  assign pos_base  = g_item.first_block ? '0 : program_position;
  assign nblk_base = g_item.first_block ? '0 : blocks_in_program;
  assign ch        = {g_geom.cyl, g_geom.head};
  assign seek      = (nblk_base == '0) || (ch != previous_cyl_head);

  always_comb begin
    priority if (g_geom.out_of_range) begin
      err = ERR_RANGE;
    end else if (nblk_base >= MAX_V) begin
      err = ERR_LONG;
    end else begin
      err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (cfg.valid) begin
      device_address <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_cyl_head <= '0;
      program_position  <= '0;
      blocks_in_program <= '0;
      e_valid           <= 1'b0;
      e_step            <= '0;
    end else begin
      if (pipe_move) begin
        e_valid <= g_valid;
        e_step  <= '0;
      end else if (command.ready) begin
        e_step <= e_step + 2'd1;
      end
      if (load) begin
        if (err != ERR_NONE) begin
          program_position  <= pos_base;
          blocks_in_program <= nblk_base;
        end else begin
          program_position  <= pos_base + (seek ? IDX_W'(4) : IDX_W'(3));
          blocks_in_program <= nblk_base + NBLK_W'(1);
          previous_cyl_head <= ch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_move) begin
      e_err  <= err;
      e_seek <= seek;
      e_pos  <= pos_base;
      e_cyl  <= g_geom.cyl;
      e_head <= g_geom.head;
      e_sec  <= g_geom.sec;
      e_rd   <= g_item.read_request;
      e_last <= g_item.last_block;
      e_buf  <= g_item.buffer_address;
    end
  end

  // without a seek the sequence starts at the search word
  assign e_kind      = word_kind_t'(e_step + {1'b0, !e_seek});
  assign e_is_last   = (e_err != ERR_NONE) || (e_kind == WK_XCHG);
  assign search_idx  = e_pos + (e_seek ? IDX_W'(1) : IDX_W'(0));
  assign seek_word   = {16'b0, e_cyl, 11'b0, e_head, e_sec, 8'b0};
  assign search_word = {e_cyl, 11'b0, e_head, e_sec, 24'b0};

  assign command.valid         = e_valid;
  assign command.unit_code     = device_address;
  assign command.program_index = e_pos + IDX_W'(e_step);
  assign command.error_code    = e_err;
  assign command.last_of_run   = e_is_last;

  always_comb begin
    command.command_code  = '0;
    command.command_flags = '0;
    command.word_count    = '0;
    command.operand       = '0;
    if (e_err == ERR_NONE) begin
      unique case (e_kind)
        WK_SEEK: begin
          command.command_code  = CMD_SEEK;
          command.command_flags = FLG_SEEK;
          command.operand       = seek_word;
        end
        WK_SEARCH: begin
          command.command_code  = CMD_SEARCH;
          command.command_flags = FLG_SEARCH;
          command.operand       = search_word;
        end
        WK_BRANCH: begin
          command.command_code  = CMD_BRANCH;
          command.command_flags = FLG_BRANCH;
          command.operand       = OPND_W'(search_idx);
        end
        WK_XCHG: begin
          command.command_code  = e_rd ? CMD_READ : CMD_WRITE;
          command.command_flags = e_last ? FLG_FINAL : FLG_XCHG;
          command.word_count    = COUNT_V;
          command.operand       = OPND_W'(e_buf);
        end
        default: begin
          command.command_code = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcpb_geom.sv =====
// ----------------------------------------------------------------------------
// dcpb_geom
// Four-stage split of a block number into cylinder, head and sector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcpb_geom import dcpb_pkg::*; #(
  parameter int CYLINDERS         = 808,
  parameter int HEADS             = 19,
  parameter int SECTORS_PER_TRACK = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       in_valid,
  input  dcpb_req_t  in_item,
  output logic       out_valid,
  output dcpb_req_t  out_item,
  output dcpb_geom_t out_geom
);

  localparam int BPC   = HEADS * SECTORS_PER_TRACK;
  localparam int TOTAL = CYLINDERS * BPC;
  // reciprocal constants: exact floor division for every input of the given width
  localparam int     L1   = $clog2(BPC);
  localparam int     SH1  = BLK_W + L1;
  localparam longint M1   = ((longint'(1) << SH1) + BPC - 1) / BPC;
  localparam int     L2   = $clog2(SECTORS_PER_TRACK);
  localparam int     SH2  = REM_W + L2;
  localparam longint M2   = ((longint'(1) << SH2) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam logic [BLK_W:0] M1_V = M1[BLK_W:0];
  localparam logic [REM_W:0] M2_V = M2[REM_W:0];

  logic [3:0] vld;

  dcpb_req_t          s1_item, s2_item, s3_item, s4_item;
  logic               s2_oor, s3_oor, s4_oor;
  logic [BLK_W-1:0]   s2_cyl;
  logic [CYL_W-1:0]   s3_cyl, s4_cyl;
  logic [REM_W-1:0]   s3_rem, s4_rem;
  logic [HEAD_W-1:0]  s4_head;

  logic [2*BLK_W:0]   prod1, quo1;
  logic [31:0]        cyl_x;
  logic [BLK_W-1:0]   rem_full;
  logic [2*REM_W+1:0] prod2, quo2;
  logic [15:0]        hs_p;
  logic [REM_W-1:0]   sec_full;

  assign prod1    = (2*BLK_W+1)'(s1_item.block_number) * (2*BLK_W+1)'(M1_V);
  assign quo1     = prod1 >> SH1;
  assign cyl_x    = 32'(s2_cyl) * 32'(BPC);
  assign rem_full = s2_item.block_number - cyl_x[BLK_W-1:0];
  assign prod2    = (2*REM_W+2)'(s3_rem) * (2*REM_W+2)'(M2_V);
  assign quo2     = prod2 >> SH2;
  assign hs_p     = 16'(s4_head) * 16'(SECTORS_PER_TRACK);
  assign sec_full = s4_rem - hs_p[REM_W-1:0] + REM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_item;

      s2_item <= s1_item;
      s2_oor  <= 32'(s1_item.block_number) >= 32'(TOTAL);
      s2_cyl  <= quo1[BLK_W-1:0];

      s3_item <= s2_item;
      s3_oor  <= s2_oor;
      s3_cyl  <= s2_cyl[CYL_W-1:0];
      s3_rem  <= rem_full[REM_W-1:0];

      s4_item <= s3_item;
      s4_oor  <= s3_oor;
      s4_cyl  <= s3_cyl;
      s4_rem  <= s3_rem;
      s4_head <= quo2[HEAD_W-1:0];
    end
  end

  assign out_valid             = vld[3];
  assign out_item              = s4_item;
  assign out_geom.out_of_range = s4_oor;
  assign out_geom.cyl          = s4_cyl;
  assign out_geom.head         = s4_head;
  assign out_geom.sec          = sec_full[SEC_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/dcpb_checker.sv =====
// ----------------------------------------------------------------------------
// dcpb_checker
// Port-level checks on the command word channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disk_channel_program_builder_unit_assert.svh"

module dcpb_checker import dcpb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic [7:0]        command_code,
  input logic [7:0]        command_flags,
  input logic [OPND_W-1:0] operand,
  input logic [IDX_W-1:0]  program_index,
  input logic [1:0]        error_code,
  input logic              last_of_run
);

  `DCPB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !cmd_valid)

  `DCPB_ASSERT(a_stall_hold, clk, rst, cmd_valid && !cmd_ready |=> cmd_valid && $stable(command_code) && $stable(operand) && $stable(program_index))

  `DCPB_ASSERT(a_error_word, clk, rst, cmd_valid && error_code != ERR_NONE |-> last_of_run && command_code == CMD_NONE && command_flags == FLG_NONE)

  `DCPB_ASSERT(a_branch_back, clk, rst, cmd_valid && error_code == ERR_NONE && command_code == CMD_BRANCH |-> operand[OPND_W-1:IDX_W] == '0 && operand[IDX_W-1:0] == IDX_W'(program_index - 6'd1))

  `DCPB_ASSERT(a_index_step, clk, rst, cmd_valid && cmd_ready && !last_of_run |=> cmd_valid && program_index == $past(program_index) + 6'd1)

endmodule

bind disk_channel_program_builder_unit dcpb_checker u_dcpb_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (command.valid),
  .cmd_ready     (command.ready),
  .command_code  (command.command_code),
  .command_flags (command.command_flags),
  .operand       (command.operand),
  .program_index (command.program_index),
  .error_code    (command.error_code),
  .last_of_run   (command.last_of_run)
);

`default_nettype wire
